/* rtl/vlc_tree_symbol_decoder_assert.svh */
// ----------------------------------------------------------------------------
// vlc_tree_symbol_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef VLC_TREE_SYMBOL_DECODER_ASSERT_SVH
`define VLC_TREE_SYMBOL_DECODER_ASSERT_SVH

// Same-cycle implication.
`define VTSD_ASSERT_IMPLY(lbl, clk, dis, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VTSD_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vtsd_pkg.sv */
// ----------------------------------------------------------------------------
// vtsd_pkg
// Types and constants of the VLC tree symbol decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vtsd_pkg;

    localparam int unsigned NODE_COUNT_DEF = 512;

    localparam int unsigned IDX_W   = 9;
    localparam int unsigned WORD_W  = 21;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned RUN_W   = 6;
    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned MAG_W   = 8;

    // node word fields
    localparam int unsigned NW_LEAF    = 20;
    localparam int unsigned NW_ONE_VLD = 19;
    localparam int unsigned NW_ZER_VLD = 18;

    localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EOB     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SIGNED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ESCAPE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DC      = 3'd4;

    localparam int unsigned ESC_RUN_BITS   = 6;
    localparam int unsigned ESC_LEVEL_BITS = 12;
    localparam int unsigned DC_MAX_SIZE    = 11;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [WORD_W-1:0] wr_word;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
    } t_mem_req;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [RUN_W-1:0]          run;
        logic signed [LEVEL_W-1:0] level;
        logic                      err;
    } t_result;

endpackage

`default_nettype wire

/* rtl/vtsd_in_if.sv */
// ----------------------------------------------------------------------------
// vtsd_in_if
// Request channel into the decoder: node writes and code bits.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtsd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [vtsd_pkg::IDX_W-1:0]   node_index;
    logic [vtsd_pkg::WORD_W-1:0]  node_word;
    logic                         code_bit;
    logic                         first_coefficient;

    modport source (
        output valid, opcode, node_index, node_word, code_bit, first_coefficient,
        input  ready
    );
    modport sink (
        input  valid, opcode, node_index, node_word, code_bit, first_coefficient,
        output ready
    );
endinterface

interface vtsd_out_if;
    logic                                valid;
    logic                                ready;
    logic [vtsd_pkg::KIND_W-1:0]         symbol_kind;
    logic [vtsd_pkg::RUN_W-1:0]          run_length;
    logic signed [vtsd_pkg::LEVEL_W-1:0] level_value;
    logic                                code_error;

    modport source (
        output valid, symbol_kind, run_length, level_value, code_error,
        input  ready
    );
    modport sink (
        input  valid, symbol_kind, run_length, level_value, code_error,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/vlc_tree_symbol_decoder.sv */
// ----------------------------------------------------------------------------
// vlc_tree_symbol_decoder
// Requests wait while a store read is in flight or the result queue is full.
// A final sign, escape or DC suffix bit pushes its result in the same cycle it is accepted.
// Tree bit: via the node store's registered read (two for the first-coefficient
// jump at the root, none when it fails on the cached current node).
// Synchronous active-low reset: walk at the root, result queue empty; the
// node store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module vlc_tree_symbol_decoder #(
    parameter int unsigned NODE_COUNT = vtsd_pkg::NODE_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vtsd_in_if.sink    i_in,
    vtsd_out_if.source o_out
);
    import vtsd_pkg::*;

    localparam int unsigned AW = $clog2(NODE_COUNT);

    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_word;
    logic              res_push;
    t_result           res;
    logic              q_full;

    vtsd_core #(
        .NODE_COUNT (NODE_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .i_rd_word  (rd_word),
        .o_mem_req  (mem_req),
        .o_res_push (res_push),
        .o_res      (res)
    );

    vtsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_node_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (AW'(mem_req.wr_idx)),
        .i_wr_data (mem_req.wr_word),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (AW'(mem_req.rd_idx)),
        .o_rd_data (rd_word)
    );

    vtsd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (q_full),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* rtl/vtsd_ram.sv */
// ----------------------------------------------------------------------------
// vtsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsd_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/vtsd_out_queue.sv */
// ----------------------------------------------------------------------------
// vtsd_out_queue
// Two-entry result queue; keeps the core running while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsd_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire vtsd_pkg::t_result i_data,
    output logic                   o_full,
    vtsd_out_if.source             o_out
);
    import vtsd_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       pop;

    assign pop    = o_out.valid && o_out.ready;
    assign o_full = (r_count == 2'd2);

    assign o_out.valid       = (r_count != 2'd0);
    assign o_out.symbol_kind = r_mem[r_rptr].kind;
    assign o_out.run_length  = r_mem[r_rptr].run;
    assign o_out.level_value = r_mem[r_rptr].level;
    assign o_out.code_error  = r_mem[r_rptr].err;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/vtsd_core.sv */
// ----------------------------------------------------------------------------
// vtsd_core
// Tree walker and suffix-bit sequencer around the node store.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsd_core #(
    parameter int unsigned NODE_COUNT = vtsd_pkg::NODE_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    vtsd_in_if.sink                          i_in,
    input  wire logic                        i_q_full,
    input  wire logic [vtsd_pkg::WORD_W-1:0] i_rd_word,
    output vtsd_pkg::t_mem_req               o_mem_req,
    output logic                             o_res_push,
    output vtsd_pkg::t_result                o_res
);
    import vtsd_pkg::*;

    localparam logic [2:0] PH_WALK      = 3'd0;
    localparam logic [2:0] PH_SIGN      = 3'd1;
    localparam logic [2:0] PH_ESC_RUN   = 3'd2;
    localparam logic [2:0] PH_ESC_LEVEL = 3'd3;
    localparam logic [2:0] PH_DC        = 3'd4;

    // store read in flight
    localparam logic [1:0] MO_NONE   = 2'd0;
    localparam logic [1:0] MO_JUMP   = 2'd1;
    localparam logic [1:0] MO_ARRIVE = 2'd2;

    logic [2:0]         r_phase,    n_phase;
    logic [1:0]         r_mo,       n_mo;
    logic [IDX_W-1:0]   r_cur_node, n_cur_node;
    logic [WORD_W-1:0]  r_cur_word, n_cur_word;
    logic [WORD_W-1:0]  r_root_word, n_root_word;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic               r_rd_oob;
    logic [3:0]         r_bits_rem, n_bits_rem;
    logic [LEVEL_W-1:0] r_acc,      n_acc;
    logic [RUN_W-1:0]   r_held_run, n_held_run;
    logic [MAG_W-1:0]   r_held_mag, n_held_mag;

    logic               fire;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               wr_en;
    logic [WORD_W-1:0]  rd_word;
    logic [LEVEL_W-1:0] acc_shift;
    logic [3:0]         rem_dec;
    logic [3:0]         dc_s;
    logic [LEVEL_W-1:0] dc_half;
    logic [LEVEL_W-1:0] dc_full;
    logic               do_res;
    t_result            res;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < NODE_COUNT;
    endfunction

    function automatic logic [3:0] dc_size(input logic [RUN_W-1:0] run);
        return (run > RUN_W'(DC_MAX_SIZE)) ? 4'(DC_MAX_SIZE) : run[3:0];
    endfunction

    assign i_in.ready = (r_mo == MO_NONE) && !i_q_full;
    assign fire       = i_in.valid && i_in.ready;

    // out-of-range entries read as an empty inner node
    assign rd_word   = r_rd_oob ? '0 : i_rd_word;
    assign acc_shift = {r_acc[LEVEL_W-2:0], i_in.code_bit};
    assign rem_dec   = (r_bits_rem != 4'd0) ? r_bits_rem - 4'd1 : 4'd0;
    assign dc_s      = dc_size(r_held_run);
    assign dc_half   = LEVEL_W'(1) << (dc_s - 4'd1);
    assign dc_full   = LEVEL_W'(1) << dc_s;

    assign wr_en = fire && !i_in.opcode && in_range(i_in.node_index);

    assign o_mem_req.wr_en   = wr_en;
    assign o_mem_req.wr_idx  = i_in.node_index;
    assign o_mem_req.wr_word = i_in.node_word;
    assign o_mem_req.rd_en   = rd_en;
    assign o_mem_req.rd_idx  = rd_idx;

    always_comb begin
        n_phase     = r_phase;
        n_mo        = r_mo;
        n_cur_node  = r_cur_node;
        n_cur_word  = r_cur_word;
        n_root_word = r_root_word;
        n_pend_idx  = r_pend_idx;
        n_bits_rem  = r_bits_rem;
        n_acc       = r_acc;
        n_held_run  = r_held_run;
        n_held_mag  = r_held_mag;
        rd_en       = 1'b0;
        rd_idx      = '0;
        do_res      = 1'b0;
        res         = '0;

        // node writes keep the cached current and root words coherent
        if (wr_en) begin
            if (i_in.node_index == r_cur_node) begin
                n_cur_word = i_in.node_word;
            end
            if (i_in.node_index == '0) begin
                n_root_word = i_in.node_word;
            end
        end

        case (r_mo)
            MO_JUMP: begin
                n_mo = MO_NONE;
                if (rd_word[NW_LEAF] || !rd_word[NW_ONE_VLD]) begin
                    do_res  = 1'b1;
                    res.err = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    rd_idx     = rd_word[2*IDX_W-1:IDX_W];
                    n_pend_idx = rd_word[2*IDX_W-1:IDX_W];
                    n_mo       = MO_ARRIVE;
                end
            end
            MO_ARRIVE: begin
                n_mo = MO_NONE;
                if (!rd_word[NW_LEAF]) begin
                    n_cur_node = r_pend_idx;
                    n_cur_word = rd_word;
                end else begin
                    n_held_run = rd_word[13:8];
                    n_held_mag = rd_word[7:0];
                    n_cur_node = '0;
                    n_cur_word = r_root_word;
                    n_acc      = '0;
                    case (rd_word[16:14])
                        KIND_SIGNED: begin
                            n_phase = PH_SIGN;
                        end
                        KIND_ESCAPE: begin
                            n_phase    = PH_ESC_RUN;
                            n_bits_rem = 4'(ESC_RUN_BITS);
                        end
                        KIND_DC: begin
                            if (rd_word[13:8] == '0) begin
                                do_res   = 1'b1;
                                res.kind = KIND_DC;
                            end else begin
                                n_phase    = PH_DC;
                                n_bits_rem = dc_size(rd_word[13:8]);
                            end
                        end
                        default: begin
                            // plain, end of block and unused kinds
                            do_res    = 1'b1;
                            res.kind  = rd_word[16:14];
                            res.run   = rd_word[13:8];
                            res.level = {4'd0, rd_word[7:0]};
                        end
                    endcase
                end
            end
            default: begin
                if (fire && i_in.opcode) begin
                    case (r_phase)
                        PH_SIGN: begin
                            do_res    = 1'b1;
                            res.kind  = KIND_SIGNED;
                            res.run   = r_held_run;
                            res.level = i_in.code_bit ? LEVEL_W'(0) - {4'd0, r_held_mag}
                                                      : {4'd0, r_held_mag};
                        end
                        PH_ESC_RUN, PH_ESC_LEVEL, PH_DC: begin
                            n_acc      = acc_shift;
                            n_bits_rem = rem_dec;
                            if (rem_dec == 4'd0) begin
                                if (r_phase == PH_ESC_RUN) begin
                                    n_held_run = acc_shift[RUN_W-1:0];
                                    n_phase    = PH_ESC_LEVEL;
                                    n_bits_rem = 4'(ESC_LEVEL_BITS);
                                    n_acc      = '0;
                                end else if (r_phase == PH_ESC_LEVEL) begin
                                    do_res    = 1'b1;
                                    res.kind  = KIND_ESCAPE;
                                    res.run   = r_held_run;
                                    res.level = acc_shift;
                                end else begin
                                    do_res    = 1'b1;
                                    res.kind  = KIND_DC;
                                    res.run   = r_held_run;
                                    // negative differential when the top bit is clear
                                    res.level = (acc_shift < dc_half)
                                              ? acc_shift + LEVEL_W'(1) - dc_full
                                              : acc_shift;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_WALK;
                            if (r_cur_word[NW_LEAF]) begin
                                do_res  = 1'b1;
                                res.err = 1'b1;
                            end else if (i_in.code_bit) begin
                                if (!r_cur_word[NW_ONE_VLD]) begin
                                    do_res  = 1'b1;
                                    res.err = 1'b1;
                                end else begin
                                    rd_en      = 1'b1;
                                    rd_idx     = r_cur_word[2*IDX_W-1:IDX_W];
                                    n_pend_idx = r_cur_word[2*IDX_W-1:IDX_W];
                                    // first coefficient: skip one level below the root
                                    n_mo = (i_in.first_coefficient && r_cur_node == '0)
                                         ? MO_JUMP : MO_ARRIVE;
                                end
                            end else begin
                                if (!r_cur_word[NW_ZER_VLD]) begin
                                    do_res  = 1'b1;
                                    res.err = 1'b1;
                                end else begin
                                    rd_en      = 1'b1;
                                    rd_idx     = r_cur_word[IDX_W-1:0];
                                    n_pend_idx = r_cur_word[IDX_W-1:0];
                                    n_mo       = MO_ARRIVE;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase

        // any result puts the walk back at the root
        if (do_res) begin
            n_cur_node = '0;
            n_cur_word = r_root_word;
            n_phase    = PH_WALK;
            n_bits_rem = 4'd0;
            n_acc      = '0;
        end
    end

    assign o_res_push = do_res;
    assign o_res      = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WALK;
            r_mo       <= MO_NONE;
            r_cur_node <= '0;
            r_rd_oob   <= 1'b0;
            r_bits_rem <= 4'd0;
            r_acc      <= '0;
            r_held_run <= '0;
            r_held_mag <= '0;
        end else begin
            r_phase    <= n_phase;
            r_mo       <= n_mo;
            r_cur_node <= n_cur_node;
            r_rd_oob   <= !in_range(rd_idx);
            r_bits_rem <= n_bits_rem;
            r_acc      <= n_acc;
            r_held_run <= n_held_run;
            r_held_mag <= n_held_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_word  <= n_cur_word;
        r_root_word <= n_root_word;
        r_pend_idx  <= n_pend_idx;
    end

endmodule

`default_nettype wire

/* rtl/vtsd_checker.sv */
// ----------------------------------------------------------------------------
// vtsd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vlc_tree_symbol_decoder_assert.svh"

module vtsd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_in_opcode,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [vtsd_pkg::KIND_W-1:0]         i_kind,
    input wire logic [vtsd_pkg::RUN_W-1:0]          i_run,
    input wire logic signed [vtsd_pkg::LEVEL_W-1:0] i_level,
    input wire logic                                i_err
);
    import vtsd_pkg::*;

    logic wr_fire;

    assign wr_fire = i_in_valid && i_in_ready && !i_in_opcode;

    `VTSD_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !i_out_valid, "result after reset")

    // a node write taken while no result waits leaves the output empty
    `VTSD_ASSERT_NEXT(a_write_silent, i_clk, !i_rst_n, !i_out_valid && wr_fire, !i_out_valid, "result from node write")

    `VTSD_ASSERT_IMPLY(a_error_clean, i_clk, !i_rst_n, i_out_valid && i_err, i_kind == KIND_PLAIN && i_run == '0 && i_level == '0, "error result with payload")

    `VTSD_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_run) && $stable(i_level) && $stable(i_err), "stalled result changed")

endmodule

bind vlc_tree_symbol_decoder vtsd_checker u_vtsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.symbol_kind),
    .i_run       (o_out.run_length),
    .i_level     (o_out.level_value),
    .i_err       (o_out.code_error)
);

`default_nettype wire
